[hdl/rc4ks_pkg.sv]
// Shared types and constants for the RC4 keystream block.
package rc4ks_pkg;

    localparam int TIME_W     = 32;
    localparam int TICK_W     = 64;
    localparam int BCNT_W     = 7;
    localparam int IN_TDATA_W = 104;
    localparam int BYTE_W     = 8;
    localparam int SBOX_DEPTH = 256;
    localparam int IDX_W      = 8;
    localparam int REM_W      = 4;
    localparam int MOD_CNT_W  = 2;
    localparam logic [REM_W:0] MIX_MOD = 5'd11;

    // 2^10 is 1 mod 11, so summing 10-bit chunks keeps the remainder
    localparam int FOLD_W     = 10;
    localparam int FOLD_N     = 7;
    localparam int FOLD_SUM_W = 13;
    // floor(x * 745 / 2^13) equals floor(x / 11) for every 10-bit x
    localparam logic [FOLD_W-1:0] MIX_RECIP = 10'd745;
    localparam int MIX_RECIP_SH = 13;

    typedef enum logic [1:0] {
        RD_I   = 2'd0,
        RD_J   = 2'd1,
        RD_SUM = 2'd2
    } rd_sel_t;

    typedef struct packed {
        logic    load;
        logic    mod_step;
        logic    mix_step;
        logic    fill;
        rd_sel_t rd_sel;
        logic    capture_si;
        logic    ksa_mode;
        logic    capture_sj;
        logic    wr_i;
        logic    wr_j;
        logic    next_i;
        logic    gen_start;
        logic    out_load;
    } cmd_t;

    typedef struct packed {
        logic mod_last;
        logic rounds_zero;
        logic i_last;
        logic cnt_last;
        logic out_free;
    } status_t;

endpackage

[hdl/rc4_keystream_from_tick_seed.sv]
// RC4 keystream generator keyed from a mixed time and tick seed: top level.
// After the request beat it reduces the tick count mod 11, runs R = tick mod 11 mixing rounds,
//   fills the 256-entry S-box, runs the key schedule over all 256 entries and then makes each byte.
// Each byte passes through the read, swap and sum-read states in turn, sharing the single S-box write port.
// One request at a time; s_axis_tready is high only between requests.
// Reset (rst_n low, asynchronous) clears the sequencer, indices and output valid;
//   the S-box is not cleared, every request refills it before reading.
module rc4_keystream_from_tick_seed #(
    parameter int MAX_REQUEST_BYTES = 64
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // [31:0] time_now, [95:32] tick_count, [102:96] byte_count, [103] zero
    input  logic [rc4ks_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [7:0] rand_byte
    output logic [rc4ks_pkg::BYTE_W-1:0]       m_axis_tdata,
    output logic                               m_axis_tlast
);

    rc4ks_pkg::cmd_t    cmd;
    rc4ks_pkg::status_t status;

    rc4ks_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    rc4ks_dp #(
        .MAX_REQUEST_BYTES (MAX_REQUEST_BYTES)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .time_now   (s_axis_tdata[31:0]),
        .tick_count (s_axis_tdata[95:32]),
        .byte_count (s_axis_tdata[102:96]),
        .cmd        (cmd),
        .status     (status),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .rand_byte  (m_axis_tdata),
        .last_byte  (m_axis_tlast)
    );

endmodule

[hdl/rc4ks_ctrl.sv]
// Sequencer for seed mixing, key schedule and keystream generation.
module rc4ks_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  rc4ks_pkg::status_t status,
    output rc4ks_pkg::cmd_t    cmd
);

    typedef enum logic [13:0] {
        ST_IDLE = 14'b00000000000001,
        ST_MOD  = 14'b00000000000010,
        ST_MIX  = 14'b00000000000100,
        ST_FILL = 14'b00000000001000,
        ST_K_RI = 14'b00000000010000,
        ST_K_RJ = 14'b00000000100000,
        ST_K_WI = 14'b00000001000000,
        ST_K_WJ = 14'b00000010000000,
        ST_G_RI = 14'b00000100000000,
        ST_G_RJ = 14'b00001000000000,
        ST_G_WI = 14'b00010000000000,
        ST_G_WJ = 14'b00100000000000,
        ST_G_RO = 14'b01000000000000,
        ST_G_OUT = 14'b10000000000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        cmd        = '0;
        cmd.rd_sel = rc4ks_pkg::RD_I;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_MOD;
                end
            end
            ST_MOD:
            begin
                cmd.mod_step = 1'b1;
                if (status.mod_last)
                begin
                    state_next = ST_MIX;
                end
            end
            ST_MIX:
            begin
                if (status.rounds_zero)
                begin
                    state_next = ST_FILL;
                end
                else
                begin
                    cmd.mix_step = 1'b1;
                end
            end
            ST_FILL:
            begin
                cmd.fill   = 1'b1;
                cmd.next_i = 1'b1;
                if (status.i_last)
                begin
                    state_next = ST_K_RI;
                end
            end
            ST_K_RI:
            begin
                cmd.rd_sel = rc4ks_pkg::RD_I;
                state_next = ST_K_RJ;
            end
            ST_K_RJ:
            begin
                cmd.rd_sel     = rc4ks_pkg::RD_J;
                cmd.capture_si = 1'b1;
                cmd.ksa_mode   = 1'b1;
                state_next     = ST_K_WI;
            end
            ST_K_WI:
            begin
                cmd.wr_i   = 1'b1;
                state_next = ST_K_WJ;
            end
            ST_K_WJ:
            begin
                cmd.wr_j = 1'b1;
                if (status.i_last)
                begin
                    cmd.gen_start = 1'b1;
                    state_next    = ST_G_RI;
                end
                else
                begin
                    cmd.next_i = 1'b1;
                    state_next = ST_K_RI;
                end
            end
            ST_G_RI:
            begin
                cmd.rd_sel = rc4ks_pkg::RD_I;
                state_next = ST_G_RJ;
            end
            ST_G_RJ:
            begin
                cmd.rd_sel     = rc4ks_pkg::RD_J;
                cmd.capture_si = 1'b1;
                state_next     = ST_G_WI;
            end
            ST_G_WI:
            begin
                cmd.wr_i       = 1'b1;
                cmd.capture_sj = 1'b1;
                state_next     = ST_G_WJ;
            end
            ST_G_WJ:
            begin
                cmd.wr_j   = 1'b1;
                state_next = ST_G_RO;
            end
            ST_G_RO:
            begin
                cmd.rd_sel = rc4ks_pkg::RD_SUM;
                state_next = ST_G_OUT;
            end
            ST_G_OUT:
            begin
                // hold the sum address so read data stays put while stalled
                cmd.rd_sel = rc4ks_pkg::RD_SUM;
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    if (status.cnt_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cmd.next_i = 1'b1;
                        state_next = ST_G_RI;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_load_starts_mod: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && in_valid) |=> (state_reg == ST_MOD))
        else $error("accepted request did not start seed reduction");

    a_gen_after_ksa: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_K_WJ && status.i_last) |=> (state_reg == ST_G_RI))
        else $error("generator did not follow the last key schedule step");

endmodule

[hdl/rc4ks_dp.sv]
// Datapath: seed mixing, S-box memory, indices, byte counter and output register.
module rc4ks_dp #(
    parameter int MAX_REQUEST_BYTES = 64
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic [rc4ks_pkg::TIME_W-1:0]     time_now,
    input  logic [rc4ks_pkg::TICK_W-1:0]     tick_count,
    input  logic [rc4ks_pkg::BCNT_W-1:0]     byte_count,
    input  rc4ks_pkg::cmd_t                  cmd,
    output rc4ks_pkg::status_t               status,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [rc4ks_pkg::BYTE_W-1:0]     rand_byte,
    output logic                             last_byte
);

    localparam int CNT_W = $clog2(MAX_REQUEST_BYTES + 1);
    localparam int IW    = rc4ks_pkg::IDX_W;
    localparam int BW    = rc4ks_pkg::BYTE_W;
    localparam int RW    = rc4ks_pkg::REM_W;
    localparam int FW    = rc4ks_pkg::FOLD_W;
    localparam int FN    = rc4ks_pkg::FOLD_N;
    localparam int FSW   = rc4ks_pkg::FOLD_SUM_W;
    localparam int QW    = 2 * FW - rc4ks_pkg::MIX_RECIP_SH;

    logic [BW-1:0] sbox [rc4ks_pkg::SBOX_DEPTH];
    logic [BW-1:0] rdata_reg;

    logic [rc4ks_pkg::TIME_W-1:0]    seed_reg;
    logic [rc4ks_pkg::TIME_W-1:0]    word_reg;
    logic [rc4ks_pkg::TICK_W-1:0]    tick_reg;
    logic [RW-1:0]                   rem_reg;
    logic [rc4ks_pkg::MOD_CNT_W-1:0] mod_cnt_reg;
    logic [IW-1:0]                   i_reg;
    logic [IW-1:0]                   j_reg;
    logic [BW-1:0]                   si_reg;
    logic [BW-1:0]                   sj_reg;
    logic [CNT_W-1:0]                count_reg;
    logic                            out_valid_reg;
    logic [BW-1:0]                   out_data_reg;
    logic                            out_last_reg;

    logic [FN*FW-1:0] tick_ext;
    logic [FSW-1:0]   fold_sum;
    logic [2*FW-1:0]  rem_prod;
    logic [QW-1:0]    rem_quot;
    logic [FW-1:0]    rem_full;
    logic [RW-1:0]    rem_next;
    logic [BW-1:0]    key_byte;
    logic [IW-1:0]    j_next;
    logic [IW-1:0]    raddr;
    logic [IW-1:0]    waddr;
    logic [BW-1:0]    wdata;
    logic             we;
    logic [CNT_W-1:0] cnt_sat;

    // fold the tick count into 10 bits: three folds bring any 64-bit value below 1024
    assign tick_ext = (FN * FW)'(tick_reg);

    always_comb
    begin
        fold_sum = '0;
        for (int k = 0; k < FN; k++)
        begin
            fold_sum = fold_sum + FSW'(tick_ext[k * FW +: FW]);
        end
    end

    // remainder of the folded value by reciprocal multiplication
    assign rem_prod = (2 * FW)'(tick_reg[FW-1:0]) * (2 * FW)'(rc4ks_pkg::MIX_RECIP);
    assign rem_quot = rem_prod[2*FW-1:rc4ks_pkg::MIX_RECIP_SH];
    assign rem_full = tick_reg[FW-1:0] - FW'(rem_quot) * FW'(rc4ks_pkg::MIX_MOD);
    assign rem_next = RW'(rem_full);

    assign key_byte = seed_reg[{i_reg[1:0], 3'b000} +: BW];
    assign j_next   = j_reg + rdata_reg + (cmd.ksa_mode ? key_byte : BW'(0));

    always_comb
    begin
        if (byte_count == '0)
        begin
            cnt_sat = CNT_W'(1);
        end
        else if (byte_count > rc4ks_pkg::BCNT_W'(MAX_REQUEST_BYTES))
        begin
            cnt_sat = CNT_W'(MAX_REQUEST_BYTES);
        end
        else
        begin
            cnt_sat = CNT_W'(byte_count);
        end
    end

    always_comb
    begin
        case (cmd.rd_sel)
            rc4ks_pkg::RD_I:   raddr = i_reg;
            rc4ks_pkg::RD_J:   raddr = j_next;
            rc4ks_pkg::RD_SUM: raddr = si_reg + sj_reg;
            default:           raddr = i_reg;
        endcase
    end

    always_comb
    begin
        we    = cmd.fill | cmd.wr_i | cmd.wr_j;
        waddr = cmd.wr_j ? j_reg : i_reg;
        if (cmd.fill)
        begin
            wdata = i_reg;
        end
        else if (cmd.wr_i)
        begin
            wdata = rdata_reg;
        end
        else
        begin
            wdata = si_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            sbox[waddr] <= wdata;
        end
        rdata_reg <= sbox[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg      <= '0;
            word_reg      <= '0;
            tick_reg      <= '0;
            rem_reg       <= '0;
            mod_cnt_reg   <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            si_reg        <= '0;
            sj_reg        <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                seed_reg    <= time_now;
                word_reg    <= tick_count[rc4ks_pkg::TIME_W-1:0];
                tick_reg    <= tick_count;
                rem_reg     <= '0;
                mod_cnt_reg <= '0;
                i_reg       <= '0;
                j_reg       <= '0;
                count_reg   <= cnt_sat;
            end
            if (cmd.mod_step)
            begin
                tick_reg    <= rc4ks_pkg::TICK_W'(fold_sum);
                rem_reg     <= rem_next;
                mod_cnt_reg <= mod_cnt_reg + 1'b1;
            end
            if (cmd.mix_step)
            begin
                seed_reg <= ((seed_reg << 1) | (seed_reg >> 7)) ^ word_reg;
                rem_reg  <= rem_reg - 1'b1;
            end
            if (cmd.capture_si)
            begin
                si_reg <= rdata_reg;
                j_reg  <= j_next;
            end
            if (cmd.capture_sj)
            begin
                sj_reg <= rdata_reg;
            end
            if (cmd.gen_start)
            begin
                i_reg <= IW'(1);
                j_reg <= '0;
            end
            else if (cmd.next_i)
            begin
                i_reg <= i_reg + 1'b1;
            end

            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
                out_data_reg  <= rdata_reg;
                out_last_reg  <= (count_reg == CNT_W'(1));
                count_reg     <= count_reg - 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign status.mod_last    = (mod_cnt_reg == '1);
    assign status.rounds_zero = (rem_reg == '0);
    assign status.i_last      = (i_reg == '1);
    assign status.cnt_last    = (count_reg == CNT_W'(1));
    assign status.out_free    = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign rand_byte = out_data_reg;
    assign last_byte = out_last_reg;

    a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.fill, cmd.wr_i, cmd.wr_j}))
        else $error("more than one S-box write in a cycle");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || out_ready))
        else $error("output beat overwritten before it was taken");

    a_load_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> (count_reg == '0))
        else $error("new request loaded while bytes remain");

    a_last_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.out_load && count_reg == CNT_W'(1)) |=> (count_reg == '0 && out_last_reg))
        else $error("last byte flag and byte counter disagree");

endmodule
